// File: src/rahs_pkg.sv
package rahs_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int ADC_BITS_DEF      = 12;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_STEPS_PER_REV = 3'd0,
        CFG_HALF_TURN     = 3'd1,
        CFG_CAL_SAMPLES   = 3'd2,
        CFG_ACCEPT_LOW    = 3'd3,
        CFG_ACCEPT_HIGH   = 3'd4,
        CFG_FLOOR_SPEED   = 3'd5,
        CFG_START_SPEED   = 3'd6
    } cfg_reg_t;

    localparam logic [15:0] STEPS_PER_REV_RESET = 16'd8200;
    localparam logic [14:0] HALF_TURN_RESET     = 15'd4100;
    localparam logic [11:0] CAL_SAMPLES_RESET   = 12'd750;
    localparam logic [11:0] ACCEPT_LOW_RESET    = 12'd505;
    localparam logic [11:0] ACCEPT_HIGH_RESET   = 12'd1000;
    localparam logic [7:0]  FLOOR_SPEED_RESET   = 8'd20;
    localparam logic [7:0]  START_SPEED_RESET   = 8'd10;

    // Threshold scale of 21/20: the divide by 20 is a shift by two and a divide by five.
    localparam int SCALE_DIV_ODD = 5;

    typedef struct packed {
        logic [15:0] steps_per_rev;
        logic [14:0] half_turn;
        logic [11:0] cal_samples;
        logic [11:0] accept_low;
        logic [11:0] accept_high;
        logic [7:0]  floor_speed;
    } cfg_t;

    typedef struct packed {
        logic direction;
        logic step_taken;
        logic homed;
        logic at_target;
    } flags_t;

endpackage

// File: src/rotary_axis_homing_and_seek_core.sv
// Rotary axis homing and seek controller for a stepper turntable.
// Input channel (in_valid / in_stall): one transaction is either a tick
// (mode 0) with a hall sensor sample and a step-due strobe, or a new
// destination (mode 1). Output channel (out_valid / out_stall): exactly one
// result transaction per input, in order, with the axis state after it.
// An accepted transaction is held in the input register, and its result is then
// registered in the axis state registers. Throughput: one transaction per cycle
// while the receiver does not stall; the state update is a single compare-and-update
// pass from the input register into the axis registers.
// The axis state registers double as the result register. When the receiver
// stalls, the result holds and in_stall rises once the input register also
// holds a transaction; nothing is dropped.
// Configuration registers are written through cfg_wr_en / cfg_index / cfg_data
// while the block is idle, a rule for the user that the block does not enforce;
// unknown indexes are ignored. Reset (rst_n, asynchronous, active low) clears
// both channels, restores the configuration defaults and returns the axis to calibration.
module rotary_axis_homing_and_seek_core #(
    parameter int POSITION_BITS = rahs_pkg::POSITION_BITS_DEF,
    parameter int ADC_BITS      = rahs_pkg::ADC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rahs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rahs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic [POSITION_BITS-1:0]            destination,
    input  logic [ADC_BITS-1:0]                 hall_sample,
    input  logic                                step_due,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [POSITION_BITS-1:0]            position,
    output logic                                direction,
    output logic                                step_taken,
    output logic                                homed,
    output logic                                at_target,
    output logic [ADC_BITS-1:0]                 threshold,
    output logic [7:0]                          speed
);

    rahs_pkg::cfg_t   cfg;
    rahs_pkg::flags_t flags;

    logic                     in_valid_reg, in_valid_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     mode_reg;
    logic [POSITION_BITS-1:0] dest_reg;
    logic [ADC_BITS-1:0]      sample_reg;
    logic                     due_reg;
    logic                     in_take;
    logic                     res_free;
    logic                     advance;

    rahs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    assign res_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && res_free;
    assign in_stall = in_valid_reg && !res_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg   <= mode;
            dest_reg   <= destination;
            sample_reg <= hall_sample;
            due_reg    <= step_due;
        end
    end

    rahs_axis #(
        .POSITION_BITS(POSITION_BITS),
        .ADC_BITS     (ADC_BITS)
    ) u_axis (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (advance),
        .cfg        (cfg),
        .mode       (mode_reg),
        .destination(dest_reg),
        .hall_sample(sample_reg),
        .step_due   (due_reg),
        .position   (position),
        .threshold  (threshold),
        .speed      (speed),
        .flags      (flags)
    );

    assign out_valid  = out_valid_reg;
    assign direction  = flags.direction;
    assign step_taken = flags.step_taken;
    assign homed      = flags.homed;
    assign at_target  = flags.at_target;

endmodule

// File: src/rahs_cfg.sv
module rahs_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rahs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rahs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output rahs_pkg::cfg_t                      cfg
);

    rahs_pkg::cfg_t cfg_reg;
    rahs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (rahs_pkg::cfg_reg_t'(cfg_index))
                rahs_pkg::CFG_STEPS_PER_REV: cfg_next.steps_per_rev = cfg_data[15:0];
                rahs_pkg::CFG_HALF_TURN:     cfg_next.half_turn     = cfg_data[14:0];
                rahs_pkg::CFG_CAL_SAMPLES:   cfg_next.cal_samples   = cfg_data[11:0];
                rahs_pkg::CFG_ACCEPT_LOW:    cfg_next.accept_low    = cfg_data[11:0];
                rahs_pkg::CFG_ACCEPT_HIGH:   cfg_next.accept_high   = cfg_data[11:0];
                rahs_pkg::CFG_FLOOR_SPEED:   cfg_next.floor_speed   = cfg_data[7:0];
                // The configuration holds no start speed, so a write to this index is ignored;
                // the speed register always resets to the package reset value.
                rahs_pkg::CFG_START_SPEED:   cfg_next = cfg_reg;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steps_per_rev <= rahs_pkg::STEPS_PER_REV_RESET;
            cfg_reg.half_turn     <= rahs_pkg::HALF_TURN_RESET;
            cfg_reg.cal_samples   <= rahs_pkg::CAL_SAMPLES_RESET;
            cfg_reg.accept_low    <= rahs_pkg::ACCEPT_LOW_RESET;
            cfg_reg.accept_high   <= rahs_pkg::ACCEPT_HIGH_RESET;
            cfg_reg.floor_speed   <= rahs_pkg::FLOOR_SPEED_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/rahs_scale.sv
module rahs_scale #(
    parameter int ADC_BITS = rahs_pkg::ADC_BITS_DEF
) (
    input  logic [ADC_BITS-1:0] thresh,
    output logic [ADC_BITS-1:0] scaled
);

    localparam int XW = ADC_BITS + 5;
    localparam int YW = XW - 2;
    localparam logic [YW-1:0] RECIP = YW'((64'd1 << YW) / rahs_pkg::SCALE_DIV_ODD);
    localparam logic [YW-1:0] ODD   = YW'(rahs_pkg::SCALE_DIV_ODD);
    localparam logic [YW-1:0] SAT   = YW'({ADC_BITS{1'b1}});

    logic [XW-1:0]   times21;
    logic [YW-1:0]   quarter;
    logic [2*YW-1:0] prod;
    logic [YW-1:0]   q_est;
    logic [YW-1:0]   rem;
    logic [YW-1:0]   quot;

    // x*21 = x*16 + x*4 + x.
    assign times21 = XW'({thresh, 4'b0000}) + XW'({thresh, 2'b00}) + XW'(thresh);
    assign quarter = times21[XW-1:2];

    // The truncated reciprocal leaves the estimate at most one below the quotient.
    assign prod  = {{YW{1'b0}}, quarter} * {{YW{1'b0}}, RECIP};
    assign q_est = prod[2*YW-1:YW];
    assign rem   = quarter - ((q_est << 2) + q_est);
    assign quot  = (rem >= ODD) ? q_est + YW'(1) : q_est;

    assign scaled = (quot > SAT) ? {ADC_BITS{1'b1}} : quot[ADC_BITS-1:0];

endmodule

// File: src/rahs_axis.sv
module rahs_axis #(
    parameter int POSITION_BITS = rahs_pkg::POSITION_BITS_DEF,
    parameter int ADC_BITS      = rahs_pkg::ADC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  rahs_pkg::cfg_t           cfg,
    input  logic                     mode,
    input  logic [POSITION_BITS-1:0] destination,
    input  logic [ADC_BITS-1:0]      hall_sample,
    input  logic                     step_due,
    output logic [POSITION_BITS-1:0] position,
    output logic [ADC_BITS-1:0]      threshold,
    output logic [7:0]               speed,
    output rahs_pkg::flags_t         flags
);

    localparam int PW = POSITION_BITS;
    localparam int CW = (PW + 1 > 17) ? PW + 1 : 17;
    localparam int DW = (PW > 15) ? PW : 15;
    localparam int AW = (ADC_BITS > 12) ? ADC_BITS : 12;

    logic [PW-1:0]       pos_reg, pos_next;
    logic [PW-1:0]       target_reg, target_next;
    logic                dir_reg, dir_next;
    logic                seeking_reg, seeking_next;
    logic [12:0]         cal_count_reg, cal_count_next;
    logic [ADC_BITS-1:0] thresh_reg, thresh_next;
    logic                homed_reg, homed_next;
    logic [7:0]          speed_reg, speed_next;
    logic                stepped_reg, stepped_next;

    logic [ADC_BITS-1:0] thresh_scaled;
    logic [CW-1:0]       pos_inc;
    logic [PW-1:0]       pos_cw;
    logic [PW-1:0]       pos_ccw;
    logic [PW-1:0]       pos_step;
    logic [PW-1:0]       dist_up;
    logic [PW-1:0]       dist_down;
    logic                seek_dir;
    logic                step_dir;
    logic                in_window;
    logic [12:0]         cal_limit;

    rahs_scale #(
        .ADC_BITS(ADC_BITS)
    ) u_scale (
        .thresh(thresh_reg),
        .scaled(thresh_scaled)
    );

    // Shorter way round: a positive gap below half a turn goes clockwise.
    assign dist_down = pos_reg - target_reg;
    assign dist_up   = target_reg - pos_reg;
    assign seek_dir  = (pos_reg > target_reg) ? !(DW'(dist_down) < DW'(cfg.half_turn))
                                              : (DW'(dist_up) < DW'(cfg.half_turn));

    assign step_dir = homed_reg ? seek_dir : dir_reg;
    assign pos_inc  = CW'(pos_reg) + CW'(1);
    assign pos_ccw  = (pos_inc >= CW'(cfg.steps_per_rev)) ? '0 : pos_inc[PW-1:0];
    assign pos_cw   = (pos_reg == '0) ? PW'(cfg.steps_per_rev - 16'd1) : pos_reg - PW'(1);
    assign pos_step = step_dir ? pos_ccw : pos_cw;

    assign in_window = (AW'(hall_sample) > AW'(cfg.accept_low)) &&
                       (AW'(hall_sample) <= AW'(cfg.accept_high));
    assign cal_limit = {1'b0, cfg.cal_samples};

    always_comb
    begin
        pos_next       = pos_reg;
        target_next    = target_reg;
        dir_next       = dir_reg;
        seeking_next   = seeking_reg;
        cal_count_next = cal_count_reg;
        thresh_next    = thresh_reg;
        homed_next     = homed_reg;
        speed_next     = speed_reg;
        stepped_next   = stepped_reg;
        if (go)
        begin
            stepped_next = 1'b0;
            if (mode)
            begin
                target_next  = destination;
                seeking_next = 1'b1;
            end
            else if (!homed_reg)
            begin
                if (cal_count_reg < cal_limit)
                begin
                    if (in_window)
                    begin
                        cal_count_next = cal_count_reg + 13'd1;
                        if (hall_sample < thresh_reg)
                            thresh_next = hall_sample;
                    end
                    stepped_next = step_due;
                    if (step_due)
                        pos_next = pos_step;
                end
                else if (cal_count_reg == cal_limit)
                begin
                    thresh_next    = thresh_scaled;
                    cal_count_next = cal_count_reg + 13'd1;
                end
                else
                begin
                    stepped_next = step_due;
                    if (step_due)
                        pos_next = pos_step;
                    // Magnet found: this point becomes the origin.
                    if (hall_sample <= thresh_reg)
                    begin
                        dir_next   = 1'b0;
                        pos_next   = '0;
                        homed_next = 1'b1;
                    end
                end
            end
            else if (seeking_reg)
            begin
                if (pos_reg == target_reg)
                begin
                    seeking_next = 1'b0;
                end
                else
                begin
                    dir_next     = seek_dir;
                    stepped_next = step_due;
                    if (step_due)
                        pos_next = pos_step;
                    if (speed_reg > cfg.floor_speed)
                        speed_next = speed_reg - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            target_reg    <= '0;
            dir_reg       <= 1'b0;
            seeking_reg   <= 1'b0;
            cal_count_reg <= '0;
            thresh_reg    <= '1;
            homed_reg     <= 1'b0;
            speed_reg     <= rahs_pkg::START_SPEED_RESET;
            stepped_reg   <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            target_reg    <= target_next;
            dir_reg       <= dir_next;
            seeking_reg   <= seeking_next;
            cal_count_reg <= cal_count_next;
            thresh_reg    <= thresh_next;
            homed_reg     <= homed_next;
            speed_reg     <= speed_next;
            stepped_reg   <= stepped_next;
        end
    end

    assign position         = pos_reg;
    assign threshold        = thresh_reg;
    assign speed            = speed_reg;
    assign flags.direction  = dir_reg;
    assign flags.step_taken = stepped_reg;
    assign flags.homed      = homed_reg;
    assign flags.at_target  = !seeking_reg;

endmodule

// File: src/rahs_checker.sv
module rahs_checker #(
    parameter int POSITION_BITS = rahs_pkg::POSITION_BITS_DEF,
    parameter int ADC_BITS      = rahs_pkg::ADC_BITS_DEF
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [POSITION_BITS-1:0] position,
    input logic                     direction,
    input logic                     homed,
    input logic [7:0]               speed
);

    // A held result keeps its position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position))
        else $error("stalled result changed");

    // The input side only backs up behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a waiting result");

    // Once homed, every later result stays homed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && homed |=> !out_valid || homed)
        else $error("homed flag dropped");

    // Before homing the axis turns clockwise and the speed is untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !homed |-> !direction && speed == rahs_pkg::START_SPEED_RESET)
        else $error("direction or speed changed before homing");

endmodule

bind rotary_axis_homing_and_seek_core rahs_checker #(
    .POSITION_BITS(POSITION_BITS),
    .ADC_BITS     (ADC_BITS)
) u_rahs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .position (position),
    .direction(direction),
    .homed    (homed),
    .speed    (speed)
);

// File: tb/rotary_axis_homing_and_seek_core_tb.sv
module rotary_axis_homing_and_seek_core_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PHASES  = 4;

    localparam logic [rahs_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 3'd7;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;
    localparam logic DIR_CW    = 1'b0;
    localparam logic DIR_CCW   = 1'b1;

    localparam logic [11:0] ADC_FULL = 12'hFFF;

    typedef struct packed {
        logic [15:0] position;
        logic        direction;
        logic        step_taken;
        logic        homed;
        logic        at_target;
        logic [11:0] threshold;
        logic [7:0]  speed;
    } axis_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [15:0] destination;
    logic [11:0] hall_sample;
    logic        step_due;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] position;
    logic        direction;
    logic        step_taken;
    logic        homed;
    logic        at_target;
    logic [11:0] threshold;
    logic [7:0]  speed;

    // Configuration as the axis currently sees it, but for cur_start_speed: the axis ignores its writes.
    logic [15:0] cur_steps_per_rev;
    logic [14:0] cur_half_turn;
    logic [11:0] cur_cal_samples;
    logic [11:0] cur_accept_low;
    logic [11:0] cur_accept_high;
    logic [7:0]  cur_floor_speed;
    logic [7:0]  cur_start_speed;

    // Predicted axis state.
    logic [15:0] axis_pos;
    logic [15:0] axis_target;
    logic        axis_dir;
    logic        axis_seeking;
    logic [12:0] cal_count;
    logic [11:0] axis_thresh;
    logic        axis_homed;
    logic [7:0]  axis_speed;

    axis_result_t expected_results[$];
    axis_result_t want;
    axis_result_t got;

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int report_count;
    int quiet_cycles;

    rotary_axis_homing_and_seek_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .destination (destination),
        .hall_sample (hall_sample),
        .step_due    (step_due),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position),
        .direction   (direction),
        .step_taken  (step_taken),
        .homed       (homed),
        .at_target   (at_target),
        .threshold   (threshold),
        .speed       (speed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic step_axis(input logic due);
        if (!due)
            return 1'b0;
        if (axis_dir == DIR_CCW)
        begin
            if ({1'b0, axis_pos} + 17'd1 >= {1'b0, cur_steps_per_rev})
                axis_pos = 16'd0;
            else
                axis_pos = axis_pos + 16'd1;
        end
        else if (axis_pos == 16'd0)
            axis_pos = cur_steps_per_rev - 16'd1;
        else
            axis_pos = axis_pos - 16'd1;
        return 1'b1;
    endfunction

    function automatic axis_result_t predict_axis_step(input logic m, input logic [15:0] dest,
                                                       input logic [11:0] hall, input logic due);
        axis_result_t r;
        logic         stepped;
        int           diff;
        int           ht;
        int           scaled;
        stepped = 1'b0;
        if (m == MODE_LOAD)
        begin
            axis_target  = dest;
            axis_seeking = 1'b1;
        end
        else if (!axis_homed)
        begin
            if (cal_count < {1'b0, cur_cal_samples})
            begin
                if (hall > cur_accept_low && hall <= cur_accept_high)
                begin
                    cal_count = cal_count + 13'd1;
                    if (hall < axis_thresh)
                        axis_thresh = hall;
                end
                stepped = step_axis(due);
            end
            else if (cal_count == {1'b0, cur_cal_samples})
            begin
                scaled      = int'(axis_thresh) * 21 / 20;
                axis_thresh = (scaled > int'(ADC_FULL)) ? ADC_FULL : scaled[11:0];
                cal_count   = cal_count + 13'd1;
            end
            else
            begin
                stepped = step_axis(due);
                if (hall <= axis_thresh)
                begin
                    axis_dir   = DIR_CW;
                    axis_pos   = 16'd0;
                    axis_homed = 1'b1;
                end
            end
        end
        else if (axis_seeking)
        begin
            diff = int'(axis_pos) - int'(axis_target);
            ht   = int'(cur_half_turn);
            if (diff == 0)
                axis_seeking = 1'b0;
            else
            begin
                // Short way round: go direct unless the distance reaches half_turn.
                if (diff > 0)
                    axis_dir = (diff < ht) ? DIR_CW : DIR_CCW;
                else
                    axis_dir = (diff > -ht) ? DIR_CCW : DIR_CW;
                stepped = step_axis(due);
                if (axis_speed > cur_floor_speed)
                    axis_speed = axis_speed - 8'd1;
            end
        end
        r.position   = axis_pos;
        r.direction  = axis_dir;
        r.step_taken = stepped;
        r.homed      = axis_homed;
        r.at_target  = !axis_seeking;
        r.threshold  = axis_thresh;
        r.speed      = axis_speed;
        return r;
    endfunction

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_axis_item(input logic m, input logic [15:0] dest,
                                  input logic [11:0] hall, input logic due);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        destination <= dest;
        hall_sample <= hall;
        step_due    <= due;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(predict_axis_step(m, dest, hall, due));
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Only used while the axis is idle, so the prediction may follow at once.
    task automatic write_axis_cfg(input logic [2:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        case (idx)
            rahs_pkg::CFG_STEPS_PER_REV: cur_steps_per_rev = value;
            rahs_pkg::CFG_HALF_TURN:     cur_half_turn     = value[14:0];
            rahs_pkg::CFG_CAL_SAMPLES:   cur_cal_samples   = value[11:0];
            rahs_pkg::CFG_ACCEPT_LOW:    cur_accept_low    = value[11:0];
            rahs_pkg::CFG_ACCEPT_HIGH:   cur_accept_high   = value[11:0];
            rahs_pkg::CFG_FLOOR_SPEED:   cur_floor_speed   = value[7:0];
            rahs_pkg::CFG_START_SPEED:   cur_start_speed   = value[7:0];
            default:                     ;
        endcase
    endtask

    task automatic test_calibration_edges();
        set_idling(0, 0);
        write_axis_cfg(rahs_pkg::CFG_STEPS_PER_REV, 16'd65535);
        write_axis_cfg(rahs_pkg::CFG_HALF_TURN, 16'd32767);
        write_axis_cfg(rahs_pkg::CFG_CAL_SAMPLES, 16'd4095);
        write_axis_cfg(rahs_pkg::CFG_ACCEPT_LOW, 16'd2900);
        write_axis_cfg(rahs_pkg::CFG_ACCEPT_HIGH, 16'd3100);
        write_axis_cfg(rahs_pkg::CFG_FLOOR_SPEED, 16'd255);
        write_axis_cfg(rahs_pkg::CFG_START_SPEED, 16'd255);
        write_axis_cfg(CFG_UNUSED_INDEX, 16'hFFFF);
        // The first clockwise step from zero wraps to the top of a full-width revolution.
        send_axis_item(MODE_TICK, 16'h0000, 12'd0, 1'b1);
        send_axis_item(MODE_TICK, 16'hFFFF, ADC_FULL, 1'b0);
        send_axis_item(MODE_TICK, 16'h0000, 12'd2900, 1'b1);
        send_axis_item(MODE_TICK, 16'h0000, 12'd2901, 1'b1);
        send_axis_item(MODE_TICK, 16'h0000, 12'd3100, 1'b0);
        send_axis_item(MODE_TICK, 16'h0000, 12'd3101, 1'b1);
        send_axis_item(MODE_TICK, 16'h0000, 12'd3000, 1'b1);
        // A destination before homing is stored and clears at_target, but the axis does not seek it until homed.
        send_axis_item(MODE_LOAD, 16'hFFFF, 12'd0, 1'b0);
        send_axis_item(MODE_LOAD, 16'h0000, ADC_FULL, 1'b1);
        send_axis_item(MODE_TICK, 16'h5A5A, 12'hA5A, 1'b1);
        send_axis_item(MODE_TICK, 16'hA5A5, 12'h5A5, 1'b1);
    endtask

    task automatic test_calibration_random();
        int SEND_IDLE[RANDOM_PHASES]  = '{0, 72, 0, 35};
        int RECV_STALL[RANDOM_PHASES] = '{0, 0, 72, 35};
        logic [11:0] lo;
        logic [11:0] hi;
        logic [11:0] hall;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_for_results();
            set_idling(SEND_IDLE[phase], RECV_STALL[phase]);
            lo = 12'($urandom_range(2800, 3300));
            // The last window is inverted, so nothing is counted in it.
            hi = (phase == RANDOM_PHASES - 1) ? lo - 12'd1
                                              : lo + 12'($urandom_range(0, 700));
            write_axis_cfg(rahs_pkg::CFG_ACCEPT_LOW, {4'd0, lo});
            write_axis_cfg(rahs_pkg::CFG_ACCEPT_HIGH, {4'd0, hi});
            write_axis_cfg(rahs_pkg::CFG_STEPS_PER_REV, 16'($urandom_range(2, 65535)));
            for (int n = 0; n < 40; n++)
            begin
                if ($urandom_range(99) < 10)
                    send_axis_item(MODE_LOAD, 16'($urandom_range(65535)),
                                   12'($urandom_range(4095)), 1'($urandom_range(1)));
                else
                begin
                    hall = $urandom_range(1) ? 12'($urandom_range(lo, hi))
                                             : 12'($urandom_range(4095));
                    send_axis_item(MODE_TICK, 16'($urandom_range(65535)), hall,
                                   1'($urandom_range(1)));
                end
            end
        end
    endtask

    task automatic test_threshold_scaling();
        wait_for_results();
        set_idling(35, 35);
        // Dropping the sample count below what was gathered skips the scaling.
        write_axis_cfg(rahs_pkg::CFG_CAL_SAMPLES, 16'd1);
        send_axis_item(MODE_TICK, 16'h0000, ADC_FULL, 1'b1);
        send_axis_item(MODE_TICK, 16'h0000, ADC_FULL, 1'b1);
        wait_for_results();
        write_axis_cfg(rahs_pkg::CFG_CAL_SAMPLES, {4'd0, cal_count[11:0]});
        send_axis_item(MODE_TICK, 16'h0000, 12'd0, 1'b1);
        repeat (3) send_axis_item(MODE_TICK, 16'h0000, axis_thresh + 12'd1,
                                  1'($urandom_range(1)));
        // Each time the count matches again the threshold is scaled once more, until it
        // saturates at full scale.
        while (axis_thresh != ADC_FULL)
        begin
            wait_for_results();
            write_axis_cfg(rahs_pkg::CFG_CAL_SAMPLES, {4'd0, cal_count[11:0]});
            send_axis_item(MODE_TICK, 16'h0000, ADC_FULL, 1'b1);
        end
        // A sample equal to the threshold finds the magnet.
        send_axis_item(MODE_TICK, 16'h0000, ADC_FULL, 1'b1);
        send_axis_item(MODE_TICK, 16'h0000, 12'd0, 1'b1);
    endtask

    task automatic test_seek_directed();
        wait_for_results();
        set_idling(0, 0);
        write_axis_cfg(rahs_pkg::CFG_STEPS_PER_REV, 16'd10);
        write_axis_cfg(rahs_pkg::CFG_HALF_TURN, 16'd5);
        write_axis_cfg(rahs_pkg::CFG_ACCEPT_LOW, 16'd0);
        write_axis_cfg(rahs_pkg::CFG_ACCEPT_HIGH, 16'd4095);
        write_axis_cfg(rahs_pkg::CFG_START_SPEED, 16'd0);
        send_axis_item(MODE_LOAD, 16'd0, 12'd0, 1'b0);
        send_axis_item(MODE_TICK, 16'd0, 12'd0, 1'b1);
        send_axis_item(MODE_LOAD, 16'd9, 12'd0, 1'b0);
        repeat (2) send_axis_item(MODE_TICK, 16'd0, 12'd0, 1'b1);
        send_axis_item(MODE_LOAD, 16'd0, 12'd0, 1'b0);
        repeat (2) send_axis_item(MODE_TICK, 16'd0, 12'd0, 1'b1);
        send_axis_item(MODE_LOAD, 16'd3, 12'd0, 1'b0);
        send_axis_item(MODE_TICK, 16'd0, 12'd0, 1'b0);
        repeat (4) send_axis_item(MODE_TICK, 16'd0, 12'd0, 1'b1);
        // Shrink the revolution below the current position.
        wait_for_results();
        write_axis_cfg(rahs_pkg::CFG_FLOOR_SPEED, 16'd0);
        write_axis_cfg(rahs_pkg::CFG_STEPS_PER_REV, 16'd2);
        send_axis_item(MODE_LOAD, 16'd0, 12'd0, 1'b0);
        repeat (4) send_axis_item(MODE_TICK, 16'd0, 12'd0, 1'b1);
        // A destination outside the revolution is never reached.
        send_axis_item(MODE_LOAD, 16'd5, 12'd0, 1'b0);
        repeat (3) send_axis_item(MODE_TICK, 16'd0, 12'd0, 1'b1);
        wait_for_results();
        write_axis_cfg(rahs_pkg::CFG_STEPS_PER_REV, 16'd65535);
        write_axis_cfg(rahs_pkg::CFG_HALF_TURN, 16'd32767);
        send_axis_item(MODE_LOAD, 16'd65534, 12'd0, 1'b0);
        repeat (2) send_axis_item(MODE_TICK, 16'd0, 12'd0, 1'b1);
    endtask

    task automatic test_seek_random();
        int SEND_IDLE[RANDOM_PHASES]  = '{0, 72, 0, 35};
        int RECV_STALL[RANDOM_PHASES] = '{0, 0, 72, 35};
        logic [15:0] revs;
        logic [15:0] dest;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_for_results();
            set_idling(SEND_IDLE[phase], RECV_STALL[phase]);
            revs = (phase == RANDOM_PHASES - 1) ? 16'($urandom_range(2, 4))
                                                : 16'($urandom_range(5, 48));
            write_axis_cfg(rahs_pkg::CFG_STEPS_PER_REV, revs);
            write_axis_cfg(rahs_pkg::CFG_HALF_TURN,
                           (phase == 2) ? 16'd32767 : 16'($urandom_range(1, revs)));
            write_axis_cfg(rahs_pkg::CFG_FLOOR_SPEED, 16'($urandom_range(0, 12)));
            for (int n = 0; n < 160; n++)
            begin
                if (phase == 1 && n == 80)
                    wait_for_results();
                if ($urandom_range(99) < 15)
                begin
                    dest = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                                    : 16'($urandom_range(0, revs - 1));
                    send_axis_item(MODE_LOAD, dest, 12'($urandom_range(4095)),
                                   1'($urandom_range(1)));
                end
                else
                    send_axis_item(MODE_TICK, 16'($urandom_range(65535)),
                                   12'($urandom_range(4095)), $urandom_range(99) < 80);
            end
        end
    endtask

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got.position   = position;
            got.direction  = direction;
            got.step_taken = step_taken;
            got.homed      = homed;
            got.at_target  = at_target;
            got.threshold  = threshold;
            got.speed      = speed;
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (report_count < REPORT_LIMIT)
                begin
                    report_count++;
                    $display("unexpected result transaction: pos=%0d", got.position);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.position !== want.position || got.direction !== want.direction ||
                    got.step_taken !== want.step_taken || got.homed !== want.homed ||
                    got.at_target !== want.at_target || got.threshold !== want.threshold ||
                    got.speed !== want.speed)
                begin
                    fail_count++;
                    if (report_count < REPORT_LIMIT)
                    begin
                        report_count++;
                        $display("exp pos=%0d dir=%0b stp=%0b hmd=%0b at=%0b thr=%0d spd=%0d",
                                 want.position, want.direction, want.step_taken, want.homed,
                                 want.at_target, want.threshold, want.speed);
                        $display("got pos=%0d dir=%0b stp=%0b hmd=%0b at=%0b thr=%0d spd=%0d",
                                 got.position, got.direction, got.step_taken, got.homed,
                                 got.at_target, got.threshold, got.speed);
                    end
                end
            end
        end
    end

    // Ends the run when no transaction moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = rahs_pkg::CFG_STEPS_PER_REV;
        cfg_data       = 16'd0;
        in_valid       = 1'b0;
        mode           = MODE_TICK;
        destination    = 16'd0;
        hall_sample    = 12'd0;
        step_due       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        cur_steps_per_rev = rahs_pkg::STEPS_PER_REV_RESET;
        cur_half_turn     = rahs_pkg::HALF_TURN_RESET;
        cur_cal_samples   = rahs_pkg::CAL_SAMPLES_RESET;
        cur_accept_low    = rahs_pkg::ACCEPT_LOW_RESET;
        cur_accept_high   = rahs_pkg::ACCEPT_HIGH_RESET;
        cur_floor_speed   = rahs_pkg::FLOOR_SPEED_RESET;
        cur_start_speed   = rahs_pkg::START_SPEED_RESET;
        axis_pos          = 16'd0;
        axis_target       = 16'd0;
        axis_dir          = DIR_CW;
        axis_seeking      = 1'b0;
        cal_count         = 13'd0;
        axis_thresh       = ADC_FULL;
        axis_homed        = 1'b0;
        axis_speed        = cur_start_speed;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_calibration_edges();
        test_calibration_random();
        test_threshold_scaling();
        test_seek_directed();
        test_seek_random();

        set_idling(0, 0);
        wait_for_results();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
